@@ sv/seu_pkg.sv @@
// ============================================================================
// seu_pkg: shared types and constants for the string escape decoder
// Item formats, the command passed from the parser to the byte generator,
// parser states, status codes and UTF-8 framing constants.
// ============================================================================
package seu_pkg;

  // Input item: one source byte or an end-of-input marker.
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } seu_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       last;
    logic [2:0] status;
  } seu_out_t;

  // Command from the parser: either one finished result, or a code point
  // that the back end expands into 1 to 4 UTF-8 bytes.
  localparam int CpWidth = 21;

  typedef struct packed {
    logic               utf8;
    logic [CpWidth-1:0] data;
    logic               byte_valid;
    logic               string_end;
    logic [2:0]         status;
  } seu_cmd_t;

  // Command queue depth.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEX
  } seu_mode_t;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_UNTERM    = 3'd1;
  localparam logic [2:0] STAT_BAD_HEX   = 3'd2;
  localparam logic [2:0] STAT_RANGE     = 3'd3;
  localparam logic [2:0] STAT_UNK_ESC   = 3'd4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [31:0] MaxCode = 32'h0010_FFFF;

  localparam logic [7:0] Utf8Cont  = 8'h80;
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Lead4 = 8'hF0;
  localparam logic [5:0] Utf8Mask  = 6'h3F;

endpackage

@@ sv/seu_front.sv @@
// ============================================================================
// seu_front: escape parser
// Accepts one source byte per cycle while the queue has room, tracks string
// and escape state, and pushes one command per byte that produces output.
// ============================================================================
module seu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  seu_pkg::seu_in_t  in_item,
  input  logic              q_full,
  output logic              cmd_push,
  output seu_pkg::seu_cmd_t cmd
);

  seu_pkg::seu_mode_t mode_r, mode_nxt;
  logic [3:0]  hex_needed_r, hex_needed_nxt;
  logic [3:0]  hex_seen_r, hex_seen_nxt;
  logic [31:0] code_accum_r, code_accum_nxt;
  logic        kind_r, kind_nxt;

  logic       acc;
  logic [7:0] c;
  logic       eoi;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic [3:0] seen_inc;
  logic [31:0] accum_inc;
  logic       hex_more;

  assign full = q_full;
  assign acc  = push && !q_full;
  assign c    = in_item.char_in;
  assign eoi  = in_item.end_of_input;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign seen_inc  = hex_seen_r + 4'd1;
  assign accum_inc = {code_accum_r[27:0], hex_val};
  assign hex_more  = hex_ok && (seen_inc < hex_needed_r);

  // Next state.
  always_comb begin
    mode_nxt = mode_r;
    if (acc) begin
      unique case (mode_r)
        seu_pkg::MODE_IDLE: begin
          if (!eoi && c == seu_pkg::CH_QUOTE) mode_nxt = seu_pkg::MODE_STR;
        end
        seu_pkg::MODE_STR: begin
          if (eoi || c == seu_pkg::CH_QUOTE) mode_nxt = seu_pkg::MODE_IDLE;
          else if (c == seu_pkg::CH_BSLASH) mode_nxt = seu_pkg::MODE_ESC;
        end
        seu_pkg::MODE_ESC: begin
          if (eoi) mode_nxt = seu_pkg::MODE_IDLE;
          else if (c == "x" || c == "u" || c == "U") mode_nxt = seu_pkg::MODE_HEX;
          else mode_nxt = seu_pkg::MODE_STR;
        end
        seu_pkg::MODE_HEX: begin
          if (eoi) mode_nxt = seu_pkg::MODE_IDLE;
          else if (!hex_more) mode_nxt = seu_pkg::MODE_STR;
        end
        default: mode_nxt = seu_pkg::MODE_IDLE;
      endcase
    end
  end

  // Command and escape registers.
  always_comb begin
    cmd_push       = 1'b0;
    cmd            = '0;
    hex_needed_nxt = hex_needed_r;
    hex_seen_nxt   = hex_seen_r;
    code_accum_nxt = code_accum_r;
    kind_nxt       = kind_r;
    if (acc && mode_r != seu_pkg::MODE_IDLE) begin
      if (eoi) begin
        cmd_push        = 1'b1;
        cmd.string_end  = 1'b1;
        cmd.status      = seu_pkg::STAT_UNTERM;
        hex_needed_nxt  = 4'd0;
        hex_seen_nxt    = 4'd0;
        code_accum_nxt  = '0;
        kind_nxt        = 1'b0;
      end else begin
        unique case (mode_r)
          seu_pkg::MODE_STR: begin
            if (c == seu_pkg::CH_QUOTE) begin
              cmd_push       = 1'b1;
              cmd.string_end = 1'b1;
            end else if (c != seu_pkg::CH_BSLASH) begin
              cmd_push       = 1'b1;
              cmd.data       = seu_pkg::CpWidth'(c);
              cmd.byte_valid = 1'b1;
            end
          end
          seu_pkg::MODE_ESC: begin
            cmd_push       = 1'b1;
            cmd.byte_valid = 1'b1;
            cmd.data       = seu_pkg::CpWidth'(c);
            unique case (c)
              "n": cmd.data = seu_pkg::CpWidth'(8'h0A);
              "r": cmd.data = seu_pkg::CpWidth'(8'h0D);
              "t": cmd.data = seu_pkg::CpWidth'(8'h09);
              "b": cmd.data = seu_pkg::CpWidth'(8'h08);
              "f": cmd.data = seu_pkg::CpWidth'(8'h0C);
              "v": cmd.data = seu_pkg::CpWidth'(8'h0B);
              "a": cmd.data = seu_pkg::CpWidth'(8'h07);
              "e": cmd.data = seu_pkg::CpWidth'(8'h1B);
              seu_pkg::CH_BSLASH, seu_pkg::CH_QUOTE: ;
              "x", "u", "U": begin
                cmd_push       = 1'b0;
                hex_needed_nxt = (c == "x") ? 4'd2 : ((c == "u") ? 4'd4 : 4'd8);
                hex_seen_nxt   = 4'd0;
                code_accum_nxt = '0;
                kind_nxt       = (c != "x");
              end
              default: begin
                if (c >= 8'h30 && c <= 8'h39) begin
                  cmd.data = seu_pkg::CpWidth'(c - 8'h30);
                end else begin
                  cmd.status = seu_pkg::STAT_UNK_ESC;
                end
              end
            endcase
          end
          seu_pkg::MODE_HEX: begin
            if (hex_more) begin
              hex_seen_nxt   = seen_inc;
              code_accum_nxt = accum_inc;
            end else begin
              cmd_push       = 1'b1;
              hex_needed_nxt = 4'd0;
              hex_seen_nxt   = 4'd0;
              code_accum_nxt = '0;
              kind_nxt       = 1'b0;
              if (!hex_ok) begin
                cmd.status = seu_pkg::STAT_BAD_HEX;
              end else if (!kind_r) begin
                cmd.byte_valid = 1'b1;
                cmd.data       = seu_pkg::CpWidth'(accum_inc[7:0]);
              end else if (accum_inc > seu_pkg::MaxCode) begin
                cmd.status = seu_pkg::STAT_RANGE;
              end else begin
                cmd.utf8       = 1'b1;
                cmd.byte_valid = 1'b1;
                cmd.data       = accum_inc[seu_pkg::CpWidth-1:0];
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= seu_pkg::MODE_IDLE;
      hex_needed_r <= 4'd0;
      hex_seen_r   <= 4'd0;
      code_accum_r <= '0;
      kind_r       <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      hex_needed_r <= hex_needed_nxt;
      hex_seen_r   <= hex_seen_nxt;
      code_accum_r <= code_accum_nxt;
      kind_r       <= kind_nxt;
    end
  end

endmodule

@@ sv/seu_queue.sv @@
// ============================================================================
// seu_queue: command queue
// Small register queue that decouples the parser from the byte generator.
// ============================================================================
module seu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  seu_pkg::seu_cmd_t wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output logic              q_valid,
  output seu_pkg::seu_cmd_t rd_data
);

  seu_pkg::seu_cmd_t mem [seu_pkg::QDepth];

  logic [seu_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [seu_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [seu_pkg::QCntW-1:0] count_r, count_nxt;

  assign q_full  = (count_r == seu_pkg::QCntW'(seu_pkg::QDepth));
  assign q_valid = (count_r != '0);
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + seu_pkg::QCntW'(wr_en) - seu_pkg::QCntW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && q_full))
    else $error("command written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && !q_valid))
    else $error("command read from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= seu_pkg::QCntW'(seu_pkg::QDepth))
    else $error("queue count above depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a write");

endmodule

@@ sv/seu_back.sv @@
// ============================================================================
// seu_back: result generator
// Turns queued commands into result items, expanding code points into their
// UTF-8 byte sequence, one result per cycle while out_item is free or popped.
// ============================================================================
module seu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  seu_pkg::seu_cmd_t head,
  output logic              rd_en,
  output logic              empty,
  input  logic              pop,
  output seu_pkg::seu_out_t out_item
);

  logic [1:0] idx_r, idx_nxt;
  logic [1:0] len_m1;
  logic       load;
  logic       is_last;
  logic [seu_pkg::CpWidth-1:0] cp;
  seu_pkg::seu_out_t res;
  seu_pkg::seu_out_t out_r;
  logic              out_valid_r, out_valid_nxt;

  assign cp = head.data;

  // Encoded length minus one.
  always_comb begin
    if (!head.utf8 || cp < 21'h80) len_m1 = 2'd0;
    else if (cp < 21'h800)         len_m1 = 2'd1;
    else if (cp < 21'h10000)       len_m1 = 2'd2;
    else                           len_m1 = 2'd3;
  end

  assign is_last = (idx_r == len_m1);
  assign load    = q_valid && (!out_valid_r || pop);
  assign rd_en   = load && is_last;

  always_comb begin
    res            = '0;
    res.byte_valid = head.byte_valid;
    res.string_end = head.string_end;
    res.status     = head.status;
    res.last       = is_last;
    unique case ({len_m1, idx_r})
      4'b01_00: res.out_byte = seu_pkg::Utf8Lead2 | {3'b000, cp[10:6]};
      4'b01_01: res.out_byte = seu_pkg::Utf8Cont | {2'b00, cp[5:0] & seu_pkg::Utf8Mask};
      4'b10_00: res.out_byte = seu_pkg::Utf8Lead3 | {4'h0, cp[15:12]};
      4'b10_01: res.out_byte = seu_pkg::Utf8Cont | {2'b00, cp[11:6]};
      4'b10_10: res.out_byte = seu_pkg::Utf8Cont | {2'b00, cp[5:0]};
      4'b11_00: res.out_byte = seu_pkg::Utf8Lead4 | {5'b00000, cp[20:18]};
      4'b11_01: res.out_byte = seu_pkg::Utf8Cont | {2'b00, cp[17:12]};
      4'b11_10: res.out_byte = seu_pkg::Utf8Cont | {2'b00, cp[11:6]};
      4'b11_11: res.out_byte = seu_pkg::Utf8Cont | {2'b00, cp[5:0]};
      default:  res.out_byte = cp[7:0];
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !pop;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (idx_r <= len_m1))
    else $error("byte index past the end of the UTF-8 sequence");

endmodule

@@ sv/string_escape_utf8_decoder_top.sv @@
// ============================================================================
// string_escape_utf8_decoder_top: string literal escape decoder, UTF-8 out
// Parses quoted strings from a byte stream, decodes escapes, and emits the
// decoded bytes with hex code points re-encoded as shortest-form UTF-8.
// ============================================================================
//
//   Channel   Handshake          Payload                Direction
//   -------   ----------------   --------------------   ---------
//   input     push / full        in_item  (seu_in_t)    into block
//   result    pop / empty        out_item (seu_out_t)   out of block
//
// One source item is taken per cycle whenever the command queue has room.
// Each item that produces output becomes one queue command; the back end
// emits one result per cycle while pop allows, so a code point holds the
// result side until all of its UTF-8 bytes are out, while input keeps
// flowing into the four-entry queue. Sustained input rate is one item per
// cycle as long as the average output stays at one result per item.
// Reset is synchronous and active low; it returns the parser to idle and
// empties the queue and the output register. A stalled result side fills
// the queue and then raises full; the parser holds its state meanwhile.
// A result passes through the command queue and the output register on its way to out_item.
//
module string_escape_utf8_decoder_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  seu_pkg::seu_in_t  in_item,
  output logic              empty,
  input  logic              pop,
  output seu_pkg::seu_out_t out_item
);

  logic              q_full;
  logic              cmd_push;
  seu_pkg::seu_cmd_t cmd;
  logic              q_valid;
  logic              rd_en;
  seu_pkg::seu_cmd_t head;

  // The parser classifies each byte and decides what, if anything, it emits.
  seu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  // The queue absorbs multi-byte UTF-8 runs and output stalls.
  seu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .q_full  (q_full),
    .rd_en   (rd_en),
    .q_valid (q_valid),
    .rd_data (head)
  );

  // The back end serializes each command into result items.
  seu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head     (head),
    .rd_en    (rd_en),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

@@ test/tb_top.sv @@
// ============================================================================
// tb_top: self-checking testbench for the string escape UTF-8 decoder
// Feeds quoted strings with plain bytes, named, digit and unknown escapes,
// hex runs, bad hex digits and cut-off input into the push/full side. Every
// decoded result that should appear is predicted and then checked field by
// field on the pop/empty side, with random idling on both sides.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import seu_pkg::*;

  localparam int RandomItems = 360;
  localparam int CycleLimit  = 200000;
  localparam int IdlePct     = 28;
  localparam int HoldCycles  = 300;

  // --------------------------------------------------------------------------
  // Decoder prediction and the list of decoded results still to come.
  // The parser state is kept here and advanced once per accepted item.
  // --------------------------------------------------------------------------
  class utf8_decode_scoreboard;
    seu_mode_t   mode;
    logic [3:0]  hex_needed;
    logic [3:0]  hex_seen;
    logic [31:0] code_accum;
    logic        code_point_esc;  // set for \u and \U, clear for \x
    seu_out_t    staged[4];
    int          n_staged;
    seu_out_t    decoded_q[$];
    int          errors;

    function new();
      mode = MODE_IDLE;
      clear_hex();
      errors = 0;
    endfunction

    function void clear_hex();
      hex_needed     = '0;
      hex_seen       = '0;
      code_accum     = '0;
      code_point_esc = 1'b0;
    endfunction

    function void start_hex(logic [3:0] digits, logic is_code_point);
      mode = MODE_HEX;
      clear_hex();
      hex_needed     = digits;
      code_point_esc = is_code_point;
    endfunction

    function bit hex_digit(input logic [7:0] c, output logic [3:0] v);
      hex_digit = 1'b1;
      v = '0;
      if (c >= "0" && c <= "9") v = c[3:0];
      else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) v = c[3:0] + 4'd9;
      else hex_digit = 1'b0;
    endfunction

    function void stage(logic [7:0] b, logic v, logic e, logic [2:0] st);
      staged[n_staged] = {b, v, e, 1'b0, st};
      n_staged++;
    endfunction

    // Shortest UTF-8 form of a code point that is already known to be in range.
    function void stage_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
        stage(cp[7:0], 1'b1, 1'b0, STAT_OK);
      end else if (cp < 21'h800) begin
        stage(Utf8Lead2 | {3'd0, cp[10:6]}, 1'b1, 1'b0, STAT_OK);
        stage(Utf8Cont | {2'd0, cp[5:0]}, 1'b1, 1'b0, STAT_OK);
      end else if (cp < 21'h10000) begin
        stage(Utf8Lead3 | {4'd0, cp[15:12]}, 1'b1, 1'b0, STAT_OK);
        stage(Utf8Cont | {2'd0, cp[11:6]}, 1'b1, 1'b0, STAT_OK);
        stage(Utf8Cont | {2'd0, cp[5:0]}, 1'b1, 1'b0, STAT_OK);
      end else begin
        stage(Utf8Lead4 | {5'd0, cp[20:18]}, 1'b1, 1'b0, STAT_OK);
        stage(Utf8Cont | {2'd0, cp[17:12]}, 1'b1, 1'b0, STAT_OK);
        stage(Utf8Cont | {2'd0, cp[11:6]}, 1'b1, 1'b0, STAT_OK);
        stage(Utf8Cont | {2'd0, cp[5:0]}, 1'b1, 1'b0, STAT_OK);
      end
    endfunction

    function void take_source_item(seu_in_t it);
      logic [7:0] c;
      logic [7:0] b;
      logic [2:0] st;
      logic [3:0] nib;
      c = it.char_in;
      n_staged = 0;
      if (mode == MODE_IDLE) begin
        if (!it.end_of_input && c == CH_QUOTE) mode = MODE_STR;
        return;
      end
      if (it.end_of_input) begin
        stage(8'h00, 1'b0, 1'b1, STAT_UNTERM);
        mode = MODE_IDLE;
        clear_hex();
      end else begin
        case (mode)
          MODE_STR: begin
            if (c == CH_QUOTE) begin
              stage(8'h00, 1'b0, 1'b1, STAT_OK);
              mode = MODE_IDLE;
            end else if (c == CH_BSLASH) begin
              mode = MODE_ESC;
            end else begin
              stage(c, 1'b1, 1'b0, STAT_OK);
            end
          end
          MODE_ESC: begin
            mode = MODE_STR;
            b = c;
            st = STAT_OK;
            case (c)
              "n": b = 8'h0A;
              "r": b = 8'h0D;
              "t": b = 8'h09;
              "b": b = 8'h08;
              "f": b = 8'h0C;
              "v": b = 8'h0B;
              "a": b = 8'h07;
              "e": b = 8'h1B;
              CH_BSLASH, CH_QUOTE: ;
              "x": start_hex(4'd2, 1'b0);
              "u": start_hex(4'd4, 1'b1);
              "U": start_hex(4'd8, 1'b1);
              default: begin
                if (c >= "0" && c <= "9") b = c - "0";
                else st = STAT_UNK_ESC;
              end
            endcase
            if (mode == MODE_STR) stage(b, 1'b1, 1'b0, st);
          end
          default: begin
            if (!hex_digit(c, nib)) begin
              stage(8'h00, 1'b0, 1'b0, STAT_BAD_HEX);
            end else begin
              code_accum = {code_accum[27:0], nib};
              hex_seen   = hex_seen + 4'd1;
              if (hex_seen >= hex_needed) begin
                if (!code_point_esc) stage(code_accum[7:0], 1'b1, 1'b0, STAT_OK);
                else if (code_accum > MaxCode) stage(8'h00, 1'b0, 1'b0, STAT_RANGE);
                else stage_utf8(code_accum[20:0]);
              end
            end
            if (n_staged != 0) begin
              mode = MODE_STR;
              clear_hex();
            end
          end
        endcase
      end
      if (n_staged > 0) staged[n_staged-1].last = 1'b1;
      for (int i = 0; i < n_staged; i++) decoded_q.push_back(staged[i]);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_decoded(seu_out_t got);
      seu_out_t want;
      if (decoded_q.size() == 0) begin
        $error("result with none expected: out_byte 0x%0h status %0d",
               got.out_byte, got.status);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      compare("out_byte", want.out_byte, got.out_byte);
      compare("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      compare("string_end", 8'(want.string_end), 8'(got.string_end));
      compare("last", 8'(want.last), 8'(got.last));
      compare("status", 8'(want.status), 8'(got.status));
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     push;
  logic     full;
  seu_in_t  in_item;
  logic     empty;
  logic     pop;
  seu_out_t out_item;

  utf8_decode_scoreboard sb;

  // While calm is set neither side idles. rx_hold asks the result side for
  // one long stall; the result process clears it when the stall is over.
  bit calm;
  bit rx_hold;
  int worked_items;  // accepted items that the parser did not simply skip
  int cycle_count;

  string_escape_utf8_decoder_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit. It is far above the slowest correct run, so reaching it means
  // the block has stopped moving items or results.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** string_escape_utf8_decoder_top: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Source side. An item is offered by raising push with the payload and is
  // taken at the first rising edge where full was low. Signals are sampled
  // right after the edge, so full still holds the value the block used at
  // that edge. Push is only lowered when a gap is inserted, never lowered and
  // raised again in the same step.
  // --------------------------------------------------------------------------
  task automatic send_item(input seu_in_t it);
    if (!calm && $urandom_range(0, 99) < IdlePct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    // The opening quote counts as work; anything else seen while idle is
    // dropped by the parser and does not count.
    if (sb.mode != MODE_IDLE || (!it.end_of_input && it.char_in == CH_QUOTE))
      worked_items++;
    sb.take_source_item(it);
  endtask

  task automatic send_char(input logic [7:0] c);
    seu_in_t it;
    it.char_in      = c;
    it.end_of_input = 1'b0;
    send_item(it);
  endtask

  // End of input carries a random, ignored byte.
  task automatic send_eoi();
    seu_in_t it;
    it.char_in      = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    send_item(it);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] base;
    if (nib < 4'd10) return "0" + {4'd0, nib};
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + {4'd0, nib} - 8'd10;
  endfunction

  task automatic send_hex(input logic [31:0] v, input int digits);
    for (int i = digits - 1; i >= 0; i--) send_char(hex_char(v[i*4 +: 4]));
  endtask

  // Code points spread over every UTF-8 length, the range edges, surrogates
  // and, for \U only, values beyond the top of the code space.
  function automatic logic [31:0] random_code(input bit eight_digits);
    case ($urandom_range(0, eight_digits ? 6 : 3))
      0: return $urandom_range(0, 32'h7F);
      1: return $urandom_range(32'h80, 32'h7FF);
      2: return $urandom_range(32'h800, 32'hFFFF);
      3: begin
        case ($urandom_range(0, 9))
          0: return 32'h0;
          1: return 32'h7F;
          2: return 32'h80;
          3: return 32'h7FF;
          4: return 32'h800;
          5: return 32'hD800;
          6: return 32'hFFFF;
          7: return 32'h10000;
          8: return 32'h10FFFF;
          default: return 32'h110000;
        endcase
      end
      4: return $urandom_range(32'h10000, 32'h10FFFF);
      5: return $urandom_range(32'h110000, 32'hFFFFFFFF);
      default: return $urandom();
    endcase
  endfunction

  // Opens a hex escape of a random kind and returns how many digits it takes.
  task automatic open_hex_escape(output int digits, output bit eight_digits);
    send_char(CH_BSLASH);
    eight_digits = 1'b0;
    case ($urandom_range(0, 2))
      0: begin send_char("x"); digits = 2; end
      1: begin send_char("u"); digits = 4; end
      default: begin send_char("U"); digits = 8; eight_digits = 1'b1; end
    endcase
  endtask

  task automatic random_token();
    string      named;
    int         sel;
    int         digits;
    bit         eight_digits;
    logic [7:0] b;
    logic [3:0] nib;
    named = "nrtbfvae\\\"";
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
      send_char(b);
    end else if (sel < 45) begin
      send_char(CH_BSLASH);
      send_char(named[$urandom_range(0, named.len() - 1)]);
    end else if (sel < 50) begin
      send_char(CH_BSLASH);
      send_char("0" + 8'($urandom_range(0, 9)));
    end else if (sel < 56) begin
      // Any byte after the backslash, mostly ones with no meaning.
      send_char(CH_BSLASH);
      send_char(8'($urandom_range(0, 255)));
    end else if (sel < 88) begin
      open_hex_escape(digits, eight_digits);
      send_hex(random_code(eight_digits), digits);
    end else begin
      // A hex run broken by a byte that is not a hex digit.
      open_hex_escape(digits, eight_digits);
      repeat ($urandom_range(0, digits - 1))
        send_char(hex_char(4'($urandom_range(0, 15))));
      do b = 8'($urandom_range(0, 255)); while (sb.hex_digit(b, nib));
      send_char(b);
    end
  endtask

  task automatic random_string();
    int sel;
    int digits;
    bit eight_digits;
    // Now and then some bytes between strings that the parser skips.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) send_eoi();
        else send_char(8'($urandom_range(0, 33)) ^ CH_QUOTE ? 8'h41 : 8'h42);
      end
    end
    send_char(CH_QUOTE);
    repeat ($urandom_range(1, 12)) random_token();
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      send_char(CH_QUOTE);
    end else if (sel < 90) begin
      send_eoi();
    end else begin
      // Input ends inside an escape or part way into a hex run.
      if ($urandom_range(0, 1)) begin
        open_hex_escape(digits, eight_digits);
        repeat ($urandom_range(0, digits - 1))
          send_char(hex_char(4'($urandom_range(0, 15))));
      end else begin
        send_char(CH_BSLASH);
      end
      send_eoi();
    end
  endtask

  task automatic wait_all_results();
    while (sb.decoded_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side. Pop idles at random except in the calm window, and once it
  // stays low for a long stretch so that the queue inside the block fills and
  // full pushes back on the source side.
  // --------------------------------------------------------------------------
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        pop <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // A result is taken at an edge where pop was high and empty was low.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_decoded(out_item);
  end

  // --------------------------------------------------------------------------
  // Stimulus: a short directed run, then random strings.
  // --------------------------------------------------------------------------
  initial begin
    bit held;
    bit drained;
    sb      = new();
    calm    = 1'b0;
    rx_hold = 1'b0;
    held    = 1'b0;
    drained = 1'b0;
    rst_n   <= 1'b0;
    push    <= 1'b0;
    in_item <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // While idle, a stray byte and an end of input give nothing.
    send_char("a");
    send_eoi();
    // A string holding the byte extremes and one escape of each simple sort.
    send_char(CH_QUOTE);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(CH_BSLASH);
    send_char("n");
    send_char(CH_BSLASH);
    send_char("q");
    send_char(CH_BSLASH);
    send_char("9");
    // Bad hex digit right after \x; the string goes on.
    send_char(CH_BSLASH);
    send_char("x");
    send_char("G");
    // The largest code point, which takes all four UTF-8 bytes.
    send_char(CH_BSLASH);
    send_char("U");
    send_hex(MaxCode, 8);
    send_char(CH_QUOTE);
    // End of input right after a backslash closes the string as unterminated.
    send_char(CH_QUOTE);
    send_char(CH_BSLASH);
    send_eoi();

    worked_items = 0;
    while (worked_items < RandomItems) begin
      // Long result stall early on while the source keeps offering items.
      if (!held && worked_items >= 60) begin
        rx_hold = 1'b1;
        held    = 1'b1;
      end
      // Later the source pauses until everything owed has come out; push
      // drops first so the last item is not taken a second time.
      if (!drained && worked_items >= 150) begin
        push <= 1'b0;
        wait_all_results();
        drained = 1'b1;
      end
      calm = worked_items >= 200 && worked_items < 280;
      random_string();
    end
    calm = 1'b0;
    push <= 1'b0;

    wait_all_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
      $display("** string_escape_utf8_decoder_top: PASSED **");
    end else begin
      $display("** string_escape_utf8_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
